[rtl/core/cle_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and ring helpers for the console line editor.
// No dependencies; cle_ctrl, cle_datapath and the core top refer to this package.
package cle_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int PTR_W     = $clog2(BUF_DEPTH);

   typedef logic [PTR_W-1:0] ptr_type;

   localparam ptr_type PTR_LAST = ptr_type'(BUF_DEPTH - 1);

   localparam logic [7:0] NOTHING_RX       = 8'hFF;
   localparam logic [7:0] CHR_CR           = 8'h0D;
   localparam logic [7:0] CHR_LF           = 8'h0A;
   localparam logic [7:0] CTRL_D           = 8'h04;
   localparam logic [7:0] CTRL_U           = 8'h15;
   localparam logic [7:0] CTRL_C           = 8'h03;
   localparam logic [7:0] ERASE_CODE_RESET = 8'd127;

   localparam logic [6:0] ERASE_MAX = 7'd127;

   localparam logic [1:0] ECHO_NONE  = 2'd0;
   localparam logic [1:0] ECHO_BYTE  = 2'd1;
   localparam logic [1:0] ECHO_CARET = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic kill_step;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_kill;
      logic is_read;
      logic ring_empty;
      logic edit_at_commit;
      logic kill_lf;
      logic kill_last;
      logic out_free;
   } status_type;

   typedef struct packed {
      logic [1:0] echo_kind;
      logic [7:0] echo_byte;
      logic [6:0] erase_count;
      logic       stop_request;
      logic       line_ready;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       read_line_end;
      logic       read_eof;
      logic       read_empty;
   } rsp_type;

   function automatic ptr_type ring_next(input ptr_type p);
      return (p == PTR_LAST) ? '0 : p + ptr_type'(1);
   endfunction

   function automatic ptr_type ring_prev(input ptr_type p);
      return (p == '0) ? PTR_LAST : p - ptr_type'(1);
   endfunction

endpackage

[rtl/core/cle_req_if.sv]
`timescale 1ns / 1ps
// Request channel: one beat is a received byte or a read of one byte.
// Stand-alone; no package needed.
interface cle_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;
   logic       read_started;

   modport source (output valid, output mode, output rx_byte, output read_started,
                   input ready);
   modport sink   (input valid, input mode, input rx_byte, input read_started,
                   output ready);
endinterface

[rtl/core/cle_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: one result beat per request beat.
// Stand-alone; no package needed.
interface cle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] echo_kind;
   logic [7:0] echo_byte;
   logic [6:0] erase_count;
   logic       stop_request;
   logic       line_ready;
   logic       read_valid;
   logic [7:0] read_byte;
   logic       read_line_end;
   logic       read_eof;
   logic       read_empty;

   modport source (output valid, output echo_kind, output echo_byte, output erase_count,
                   output stop_request, output line_ready, output read_valid,
                   output read_byte, output read_line_end, output read_eof,
                   output read_empty, input ready);
   modport sink   (input valid, input echo_kind, input echo_byte, input erase_count,
                   input stop_request, input line_ready, input read_valid,
                   input read_byte, input read_line_end, input read_eof,
                   input read_empty, output ready);
endinterface

[rtl/core/cle_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the line editor: accept, decode, kill walk, read, emit.
// Depends on cle_pkg (cmd_type, status_type).
module cle_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cle_pkg::status_type status,
   output cle_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_KILL,
      S_RDATA,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.is_kill && !status.edit_at_commit) begin
               state_in = S_KILL;
            end else if (status.is_read && !status.ring_empty) begin
               state_in = S_RDATA;   // slot data lands next cycle
            end else begin
               cmd.exec = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_KILL: begin
            if (status.kill_lf) begin
               cmd.exec = 1'b1;
               state_in = S_EMIT;
            end else begin
               cmd.kill_step = 1'b1;
               if (status.kill_last) begin
                  cmd.exec = 1'b1;
                  state_in = S_EMIT;
               end
            end
         end
         S_RDATA: begin
            cmd.exec = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_cmd_phases: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.exec, cmd.emit}))
      else $error("capture, exec and emit overlap");

   a_kill_class: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KILL) |-> status.is_kill)
      else $error("kill walk on a beat that is not a line kill");
`endif

endmodule

[rtl/core/cle_datapath.sv]
`timescale 1ns / 1ps
// Line editor datapath: ring store, positions, erase code, result and output registers.
// Depends on cle_pkg (types, constants, ring helpers).
module cle_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                req_mode,
   input  logic [7:0]          req_rx_byte,
   input  logic                req_read_started,
   input  cle_pkg::cmd_type    cmd,
   output cle_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cle_pkg::rsp_type    rsp_data
);

   logic [7:0] line_store_mem [cle_pkg::BUF_DEPTH];

   logic             mode_ff;
   logic [7:0]       rx_ff;
   logic             started_ff;
   logic [7:0]       erase_code_ff;
   cle_pkg::ptr_type read_ff, read_in;
   cle_pkg::ptr_type commit_ff, commit_in;
   cle_pkg::ptr_type edit_ff, edit_in;
   logic [6:0]       n_ff, n_in;
   logic [7:0]       rd_data_ff;
   cle_pkg::rsp_type res_ff, res_in;
   cle_pkg::rsp_type out_ff;
   logic             out_valid_ff, out_valid_in;

   logic [7:0]       c_map;
   logic             is_rx, is_erase, is_kill, is_intr, is_store;
   cle_pkg::ptr_type edit_nx, edit_pv, read_nx, rd_addr;
   logic             ring_empty, edit_at_commit, ring_full, mem_we;

   // beat decode, CR folded to LF first
   assign c_map    = (rx_ff == cle_pkg::CHR_CR) ? cle_pkg::CHR_LF : rx_ff;
   assign is_rx    = !mode_ff && (rx_ff != cle_pkg::NOTHING_RX);
   assign is_erase = is_rx && (c_map == erase_code_ff);
   assign is_kill  = is_rx && !is_erase && (c_map == cle_pkg::CTRL_U);
   assign is_intr  = is_rx && !is_erase && !is_kill && (c_map == cle_pkg::CTRL_C);
   assign is_store = is_rx && !is_erase && !is_kill && !is_intr;

   assign edit_nx        = cle_pkg::ring_next(edit_ff);
   assign edit_pv        = cle_pkg::ring_prev(edit_ff);
   assign read_nx        = cle_pkg::ring_next(read_ff);
   assign ring_empty     = (read_ff == commit_ff);
   assign edit_at_commit = (edit_ff == commit_ff);
   assign ring_full      = (edit_nx == read_ff);

   assign status.is_kill        = is_kill;
   assign status.is_read        = mode_ff;
   assign status.ring_empty     = ring_empty;
   assign status.edit_at_commit = edit_at_commit;
   assign status.kill_lf        = (rd_data_ff == cle_pkg::CHR_LF);
   assign status.kill_last      = (edit_pv == commit_ff);
   assign status.out_free       = !out_valid_ff || rsp_ready;

   always_comb begin
      edit_in   = edit_ff;
      commit_in = commit_ff;
      read_in   = read_ff;
      n_in      = n_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      if (cmd.capture) begin
         n_in = '0;
      end
      if (cmd.kill_step) begin
         edit_in = edit_pv;
         n_in    = (n_ff == cle_pkg::ERASE_MAX) ? n_ff : n_ff + 7'd1;
      end
      if (cmd.exec) begin
         res_in = '0;
         if (is_erase) begin
            if (!edit_at_commit) begin
               edit_in            = edit_pv;
               res_in.erase_count = 7'd1;
            end
         end else if (is_kill) begin
            res_in.erase_count = n_in;
         end else if (is_intr) begin
            res_in.echo_kind    = cle_pkg::ECHO_CARET;
            res_in.stop_request = 1'b1;
         end else if (is_store) begin
            if (!ring_full) begin
               mem_we           = 1'b1;
               edit_in          = edit_nx;
               res_in.echo_kind = cle_pkg::ECHO_BYTE;
               res_in.echo_byte = c_map;
               if (c_map == cle_pkg::CTRL_D || c_map == cle_pkg::CHR_LF ||
                   cle_pkg::ring_next(edit_nx) == read_ff) begin
                  commit_in         = edit_nx;
                  res_in.line_ready = 1'b1;
               end
            end
         end else if (mode_ff) begin
            if (ring_empty) begin
               res_in.read_empty = 1'b1;
            end else if (rd_data_ff == cle_pkg::CTRL_D) begin
               res_in.read_eof = 1'b1;
               if (!started_ff) begin
                  read_in = read_nx;
               end
            end else begin
               read_in              = read_nx;
               res_in.read_valid    = 1'b1;
               res_in.read_byte     = rd_data_ff;
               res_in.read_line_end = (rd_data_ff == cle_pkg::CHR_LF);
            end
         end
      end
   end

   // kill walks the edit position; everything else reads the slot after read_pos
   assign rd_addr = is_kill ? edit_in : read_nx;

   assign out_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_mem[edit_nx] <= c_map;
      end
      rd_data_ff <= line_store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff    <= req_mode;
         rx_ff      <= req_rx_byte;
         started_ff <= req_read_started;
      end
      if (cmd.emit) begin
         out_ff <= res_ff;
      end
      res_ff <= res_in;
      n_ff   <= n_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_code_ff <= cle_pkg::ERASE_CODE_RESET;
         read_ff       <= '0;
         commit_ff     <= '0;
         edit_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            erase_code_ff <= csr_wr_data;
         end
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   a_kill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.kill_step |-> (edit_ff != commit_ff))
      else $error("kill step past the commit point");

   a_commit_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(commit_ff)) |-> $past(cmd.exec && is_store))
      else $error("commit point moved outside a store");
`endif

endmodule

[rtl/core/console_line_editor_core.sv]
`timescale 1ns / 1ps
// Console line editor top: canonical line editing over a BUF_DEPTH-byte ring.
// Flow: each request beat is captured, decoded and executed into the result register, then
// emitted to the output register; byte reads pass a slot read state first, and a line kill
// walks back one store read per byte, stopping at a newline. A beat is taken only once the last is emitted.
// Reset: positions to zero, erase code to 127; the line store is not cleared (no sweep).
// Depends on cle_pkg, cle_req_if, cle_rsp_if, cle_ctrl, cle_datapath.
module console_line_editor_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   cle_req_if.sink    req_ch,
   cle_rsp_if.source  rsp_ch
);

   // Controller and datapath talk only through these two bundles.
   cle_pkg::cmd_type    cmd;
   cle_pkg::status_type status;
   cle_pkg::rsp_type    rsp_data;
   logic                rsp_valid;
   logic                req_ready;

   // Sequencer: takes a request beat only when idle. A finished result
   // sits in the output register, so the next beat can be taken while the
   // sink stalls; only the emit step waits for the output slot.
   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: ring store (single write, registered read), read/commit/edit
   // positions, erase code register, result staging and output register.
   cle_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_mode         (req_ch.mode),
      .req_rx_byte      (req_ch.rx_byte),
      .req_read_started (req_ch.read_started),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_data         (rsp_data)
   );

   assign req_ch.ready = req_ready;

   // Output beat: fields straight from the output register.
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.echo_kind     = rsp_data.echo_kind;
   assign rsp_ch.echo_byte     = rsp_data.echo_byte;
   assign rsp_ch.erase_count   = rsp_data.erase_count;
   assign rsp_ch.stop_request  = rsp_data.stop_request;
   assign rsp_ch.line_ready    = rsp_data.line_ready;
   assign rsp_ch.read_valid    = rsp_data.read_valid;
   assign rsp_ch.read_byte     = rsp_data.read_byte;
   assign rsp_ch.read_line_end = rsp_data.read_line_end;
   assign rsp_ch.read_eof      = rsp_data.read_eof;
   assign rsp_ch.read_empty    = rsp_data.read_empty;

endmodule
